### src/dsbp_pkg.sv
package dsbp_pkg;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EXP   = 8'h45;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int RADIX = 10;

    // Limits
    localparam int          SCALE_W   = 17;
    localparam logic [16:0] SCALE_SAT = 17'h1FFFF;
    localparam int          EXP_W     = 16;
    localparam logic [19:0] EXP_MAX   = 20'd32767;
    localparam int          OUT_CNT_W = 16;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SYNTAX = 2'd1;
    localparam logic [1:0] ERR_EXPOVF = 2'd2;
    localparam logic [1:0] ERR_SCLOVF = 2'd3;

    // Queue depths
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

    typedef enum logic [3:0] {
        PH_SIGN  = 4'd0,
        PH_LZERO = 4'd1,
        PH_INT   = 4'd2,
        PH_FZERO = 4'd3,
        PH_FRAC  = 4'd4,
        PH_EMARK = 4'd5,
        PH_ESIGN = 4'd6,
        PH_EZERO = 4'd7,
        PH_EDIG  = 4'd8,
        PH_ERR   = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        CC_ZERO,
        CC_DIGIT,
        CC_DOT,
        CC_EXP,
        CC_MINUS,
        CC_PLUS,
        CC_SPACE,
        CC_OTHER
    } char_class_t;

    // Classified character, front to back
    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
    } cq_entry_t;

    typedef struct packed {
        logic               kind;
        logic [3:0]         digit;
        logic               sign;
        logic [15:0]        digit_count;
        logic signed [15:0] scale;
        logic [1:0]         error;
        logic               end_of_run;
    } result_t;

endpackage

### src/dsbp_front.sv
module dsbp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           ch,
    input  logic                 last,
    output logic                 q_valid,
    output dsbp_pkg::cq_entry_t  q_entry,
    input  logic                 q_pop
);

    dsbp_pkg::cq_entry_t        mem [dsbp_pkg::CQ_DEPTH];
    logic [dsbp_pkg::CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dsbp_pkg::CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dsbp_pkg::CQ_PTR_W:0]   count_reg, count_next;
    logic                          push;
    dsbp_pkg::cq_entry_t           entry;

    function automatic dsbp_pkg::char_class_t classify(input logic [7:0] c);
        dsbp_pkg::char_class_t k;
        if (c == dsbp_pkg::CH_ZERO)
            k = dsbp_pkg::CC_ZERO;
        else if (c > dsbp_pkg::CH_ZERO && c <= dsbp_pkg::CH_NINE)
            k = dsbp_pkg::CC_DIGIT;
        else if (c == dsbp_pkg::CH_DOT)
            k = dsbp_pkg::CC_DOT;
        else if (c == dsbp_pkg::CH_EXP)
            k = dsbp_pkg::CC_EXP;
        else if (c == dsbp_pkg::CH_MINUS)
            k = dsbp_pkg::CC_MINUS;
        else if (c == dsbp_pkg::CH_PLUS)
            k = dsbp_pkg::CC_PLUS;
        else if (c == dsbp_pkg::CH_SPACE)
            k = dsbp_pkg::CC_SPACE;
        else
            k = dsbp_pkg::CC_OTHER;
        return k;
    endfunction

    always_comb
    begin
        entry.cls   = classify(ch);
        entry.digit = (entry.cls == dsbp_pkg::CC_DIGIT) ? 4'(ch - dsbp_pkg::CH_ZERO) : 4'd0;
        entry.last  = last;
    end

    assign in_stall = (count_reg == (dsbp_pkg::CQ_PTR_W+1)'(dsbp_pkg::CQ_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (q_pop ? 1'b1 : 1'b0);
        count_next  = count_reg + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= entry;
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("class queue popped while empty");

endmodule

### src/dsbp_back.sv
module dsbp_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  dsbp_pkg::cq_entry_t  q_entry,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dsbp_pkg::result_t    out_res
);

    localparam int WIDE_W = (COUNT_WIDTH > dsbp_pkg::OUT_CNT_W) ? COUNT_WIDTH
                                                                : dsbp_pkg::OUT_CNT_W;

    // Parse state
    dsbp_pkg::phase_t                 phase_reg, phase_next;
    logic                             neg_reg, neg_next;
    logic                             eneg_reg, eneg_next;
    logic [dsbp_pkg::EXP_W-1:0]       exp_reg, exp_next;
    logic [dsbp_pkg::SCALE_W-1:0]     scale_reg, scale_next;
    logic [COUNT_WIDTH-1:0]           digits_reg, digits_next;
    logic [1:0]                       err_reg, err_next;

    // Result queue
    dsbp_pkg::result_t                rmem [dsbp_pkg::RQ_DEPTH];
    logic [dsbp_pkg::RQ_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dsbp_pkg::RQ_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [dsbp_pkg::RQ_PTR_W:0]      count_reg, count_next;

    logic       is_zero, is_dig, emit;
    logic       do_int, do_frac, do_emark, do_ezero, do_edig;
    logic [19:0] exp_mac;
    logic signed [18:0] sc_full;
    logic       sc_ovf;
    logic [1:0] fin_err;
    logic [WIDE_W-1:0] cnt_wide;
    logic [15:0] cnt_out;
    dsbp_pkg::result_t dig_res, sum_res, res0;
    logic       pop_out;
    logic [1:0] n_push;

    assign is_zero = (q_entry.cls == dsbp_pkg::CC_ZERO);
    assign is_dig  = is_zero || (q_entry.cls == dsbp_pkg::CC_DIGIT);
    assign exp_mac = {1'b0, exp_reg, 3'b000} + {3'b000, exp_reg, 1'b0} + {16'd0, q_entry.digit};

    // Character step, written as a set of handlers that chain like the grammar
    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        eneg_next   = eneg_reg;
        exp_next    = exp_reg;
        scale_next  = scale_reg;
        digits_next = digits_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        do_int      = 1'b0;
        do_frac     = 1'b0;
        do_emark    = 1'b0;
        do_ezero    = 1'b0;
        do_edig     = 1'b0;

        unique case (phase_reg)
            dsbp_pkg::PH_SIGN:
            begin
                if (is_zero)
                    phase_next = dsbp_pkg::PH_SIGN;
                else if (q_entry.cls == dsbp_pkg::CC_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = dsbp_pkg::PH_LZERO;
                end
                else if (q_entry.cls == dsbp_pkg::CC_PLUS)
                begin
                    neg_next   = 1'b0;
                    phase_next = dsbp_pkg::PH_LZERO;
                end
                else
                    do_int = 1'b1;
            end
            dsbp_pkg::PH_LZERO:
            begin
                if (!is_zero)
                    do_int = 1'b1;
            end
            dsbp_pkg::PH_INT:
                do_int = 1'b1;
            dsbp_pkg::PH_FZERO:
            begin
                if (is_zero)
                begin
                    if (scale_reg != dsbp_pkg::SCALE_SAT)
                        scale_next = scale_reg + 1'b1;
                end
                else
                    do_frac = 1'b1;
            end
            dsbp_pkg::PH_FRAC:
                do_frac = 1'b1;
            dsbp_pkg::PH_EMARK:
                do_emark = 1'b1;
            dsbp_pkg::PH_ESIGN:
            begin
                if (q_entry.cls == dsbp_pkg::CC_MINUS)
                begin
                    eneg_next  = 1'b1;
                    phase_next = dsbp_pkg::PH_EZERO;
                end
                else if (q_entry.cls == dsbp_pkg::CC_PLUS)
                begin
                    eneg_next  = 1'b0;
                    phase_next = dsbp_pkg::PH_EZERO;
                end
                else
                    do_ezero = 1'b1;
            end
            dsbp_pkg::PH_EZERO:
                do_ezero = 1'b1;
            dsbp_pkg::PH_EDIG:
                do_edig = 1'b1;
            default:
                phase_next = phase_reg;
        endcase

        if (do_ezero)
        begin
            phase_next = dsbp_pkg::PH_EZERO;
            if (!is_zero)
                do_edig = 1'b1;
        end

        if (do_int)
        begin
            if (is_dig)
            begin
                if (digits_reg != '1)
                    digits_next = digits_reg + 1'b1;
                emit       = 1'b1;
                phase_next = dsbp_pkg::PH_INT;
            end
            else if (q_entry.cls == dsbp_pkg::CC_DOT)
                phase_next = (digits_reg != '0) ? dsbp_pkg::PH_FRAC : dsbp_pkg::PH_FZERO;
            else
                do_emark = 1'b1;
        end

        if (do_frac)
        begin
            if (is_dig)
            begin
                if (digits_reg != '1)
                    digits_next = digits_reg + 1'b1;
                if (scale_reg != dsbp_pkg::SCALE_SAT)
                    scale_next = scale_reg + 1'b1;
                emit       = 1'b1;
                phase_next = dsbp_pkg::PH_FRAC;
            end
            else
                do_emark = 1'b1;
        end

        if (do_emark)
        begin
            if (q_entry.cls == dsbp_pkg::CC_SPACE)
                phase_next = dsbp_pkg::PH_EMARK;
            else if (q_entry.cls == dsbp_pkg::CC_EXP)
                phase_next = dsbp_pkg::PH_ESIGN;
            else
            begin
                phase_next = dsbp_pkg::PH_ERR;
                err_next   = dsbp_pkg::ERR_SYNTAX;
            end
        end

        if (do_edig)
        begin
            if (is_dig)
            begin
                if (exp_mac > dsbp_pkg::EXP_MAX)
                begin
                    phase_next = dsbp_pkg::PH_ERR;
                    err_next   = dsbp_pkg::ERR_EXPOVF;
                end
                else
                begin
                    exp_next   = exp_mac[dsbp_pkg::EXP_W-1:0];
                    phase_next = dsbp_pkg::PH_EDIG;
                end
            end
            else
            begin
                phase_next = dsbp_pkg::PH_ERR;
                err_next   = dsbp_pkg::ERR_SYNTAX;
            end
        end
    end

    // Summary from the state after this character
    always_comb
    begin
        if (eneg_next)
            sc_full = $signed({2'b00, scale_next}) + $signed({3'b000, exp_next});
        else
            sc_full = $signed({2'b00, scale_next}) - $signed({3'b000, exp_next});
        sc_ovf   = (sc_full > 19'sd32767) || (sc_full < -19'sd32768);
        if (err_next != dsbp_pkg::ERR_NONE)
            fin_err = err_next;
        else if (sc_ovf)
            fin_err = dsbp_pkg::ERR_SCLOVF;
        else
            fin_err = dsbp_pkg::ERR_NONE;

        cnt_wide = WIDE_W'(digits_next);
        cnt_out  = (cnt_wide > WIDE_W'(16'hFFFF)) ? 16'hFFFF : cnt_wide[15:0];

        sum_res             = '0;
        sum_res.kind        = 1'b1;
        sum_res.digit_count = cnt_out;
        sum_res.error       = fin_err;
        sum_res.end_of_run  = 1'b1;
        if (fin_err == dsbp_pkg::ERR_NONE && digits_next != '0)
        begin
            sum_res.sign  = neg_next;
            sum_res.scale = sc_full[15:0];
        end

        dig_res       = '0;
        dig_res.digit = q_entry.digit;

        res0   = emit ? dig_res : sum_res;
        n_push = {1'b0, emit} + {1'b0, q_entry.last};
    end

    // Take a character only when the result queue can absorb two beats
    assign q_pop     = q_valid && (count_reg <= (dsbp_pkg::RQ_PTR_W+1)'(dsbp_pkg::RQ_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = rmem[rd_ptr_reg];
    assign pop_out   = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (q_pop ? n_push : 2'd0);
        rd_ptr_next = rd_ptr_reg + (pop_out ? 1'b1 : 1'b0);
        count_next  = count_reg + (q_pop ? n_push : 2'd0) - (pop_out ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dsbp_pkg::PH_SIGN;
            neg_reg    <= 1'b0;
            eneg_reg   <= 1'b0;
            exp_reg    <= '0;
            scale_reg  <= '0;
            digits_reg <= '0;
            err_reg    <= dsbp_pkg::ERR_NONE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (q_pop)
            begin
                if (q_entry.last)
                begin
                    phase_reg  <= dsbp_pkg::PH_SIGN;
                    neg_reg    <= 1'b0;
                    eneg_reg   <= 1'b0;
                    exp_reg    <= '0;
                    scale_reg  <= '0;
                    digits_reg <= '0;
                    err_reg    <= dsbp_pkg::ERR_NONE;
                end
                else
                begin
                    phase_reg  <= phase_next;
                    neg_reg    <= neg_next;
                    eneg_reg   <= eneg_next;
                    exp_reg    <= exp_next;
                    scale_reg  <= scale_next;
                    digits_reg <= digits_next;
                    err_reg    <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && n_push != 2'd0)
            rmem[wr_ptr_reg] <= res0;
        if (q_pop && n_push == 2'd2)
            rmem[wr_ptr_reg + 1'b1] <= sum_res;
    end

    a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (dsbp_pkg::RQ_PTR_W+1)'(dsbp_pkg::RQ_DEPTH))
        else $error("result queue overrun");

    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dsbp_pkg::PH_ERR) == (err_reg != dsbp_pkg::ERR_NONE))
        else $error("error code and error phase disagree");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_entry.last) |=> (phase_reg == dsbp_pkg::PH_SIGN && digits_reg == '0))
        else $error("state not cleared after end of string");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        {4'd0, exp_reg} <= dsbp_pkg::EXP_MAX)
        else $error("exponent register above limit");

    a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_res.kind) |-> out_res.digit <= 4'd9)
        else $error("digit beat holds a non-BCD value");

endmodule

### src/decimal_string_to_bcd_parser_top.sv
// Decimal string to BCD parser. Feed one ASCII character per input beat,
// with last set on the final character. Each significant digit comes out
// as a digit beat (kind 0) as soon as it is parsed; the last character adds
// a summary beat (kind 1, end_of_run 1) with sign, digit count, scale
// (fraction digits minus exponent) and error code. Sustained rate is one
// character per cycle unless the result side stalls; only the summary
// costs an extra result beat, since the result side drains one beat per
// cycle. Characters are registered in a four-entry class queue in front of
// the parser and results in a four-entry result queue behind it, so both
// sides can stall independently. After a syntax or overflow error the rest
// of the string is ignored and its summary reports the error with sign and
// scale forced to zero; a string with no significant digit reports zero
// sign and scale. No clearing pass after reset.
module decimal_string_to_bcd_parser_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // character side
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         ch,
    input  logic               last,
    // result side
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [3:0]         digit,
    output logic               sign,
    output logic [15:0]        digit_count,
    output logic signed [15:0] scale,
    output logic [1:0]         error,
    output logic               end_of_run
);

    logic                q_valid;
    logic                q_pop;
    dsbp_pkg::cq_entry_t q_entry;
    dsbp_pkg::result_t   res;

    // Front: classify characters and buffer them
    dsbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .last     (last),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    // Back: grammar state, counters and the result queue
    dsbp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res)
    );

    // Unpack the result beat onto the field ports
    assign kind        = res.kind;
    assign digit       = res.digit;
    assign sign        = res.sign;
    assign digit_count = res.digit_count;
    assign scale       = res.scale;
    assign error       = res.error;
    assign end_of_run  = res.end_of_run;

endmodule

### bench/testbench.sv
module testbench;

    // Bench for the decimal string to BCD parser.
    //
    // Strings go in one character per input beat, last set on the final one.
    // A predictor runs alongside: for every accepted character it updates its own
    // parse state and queues the beats the block should send back (a digit beat
    // per significant digit, a summary beat on last). Every accepted output beat
    // is popped and checked field by field.
    //
    // Stimulus, in order:
    //   - a short table of strings: leading zero before the sign, zero value with
    //     a sign, space before the exponent marker, a string that stops right
    //     after the exponent sign, a syntax error with trailing input ignored,
    //     exponent overflow and scale overflow. Rows with an obvious summary carry
    //     it typed in; the rest rely on the predictor.
    //   - random strings: mostly well formed numbers with random content
    //     (digits, fraction, spaces, exponent near the overflow boundary), plus
    //     corrupted strings and raw byte noise.
    //   - one long negative integer, a couple hundred digits.
    // The sender works in bursts with random gaps; the receiver stalls in styles
    // that change at random intervals (free flow, sparse, periodic, runs).

    localparam int          COUNT_W      = 16;
    localparam int          RANDOM_ITEMS = 900;
    localparam int          LONG_RUN     = 200;
    localparam int          DRAIN_TAIL   = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          EXP_LIMIT    = 32767;
    localparam logic [16:0] SCALE_TOP    = '1;
    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    typedef enum int {
        FLOW_FREE,
        FLOW_SPARSE,
        FLOW_PERIODIC,
        FLOW_RUNS
    } stall_style_t;

    // one directed string; summary fields used only when typed is set
    typedef struct {
        string              text;
        bit                 typed;
        logic               sign;
        logic [15:0]        count;
        logic signed [15:0] scale;
        logic [1:0]         err;
    } row_t;

    row_t dir_rows[7] = '{
        '{"0",         1'b1, 1'b0, 16'd0, 16'sd0, dsbp_pkg::ERR_NONE},
        '{"0-9.05",    1'b0, 1'b0, 16'd0, 16'sd0, dsbp_pkg::ERR_NONE},
        '{"-.0",       1'b1, 1'b0, 16'd0, 16'sd0, dsbp_pkg::ERR_NONE},
        '{"7 E-",      1'b0, 1'b0, 16'd0, 16'sd0, dsbp_pkg::ERR_NONE},
        '{"\3775",     1'b1, 1'b0, 16'd0, 16'sd0, dsbp_pkg::ERR_SYNTAX},
        '{"E40000",    1'b1, 1'b0, 16'd0, 16'sd0, dsbp_pkg::ERR_EXPOVF},
        '{".1E-32767", 1'b1, 1'b0, 16'd1, 16'sd0, dsbp_pkg::ERR_SCLOVF}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         ch = 8'd0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               kind;
    logic [3:0]         digit;
    logic               sign;
    logic [15:0]        digit_count;
    logic signed [15:0] scale;
    logic [1:0]         error;
    logic               end_of_run;

    // predictor state
    dsbp_pkg::phase_t    num_phase;
    logic                num_neg;
    logic                exp_neg;
    logic [15:0]         exp_mag;
    logic [16:0]         frac_scale;
    logic [COUNT_W-1:0]  sig_digits;
    logic [1:0]          parse_err;

    dsbp_pkg::result_t parsed_beats[$];   // beats owed by the block, oldest first
    logic [7:0]  num_text[$];       // string being sent
    int          row_tag = -1;      // table row of the beat on the bus, -1 if random
    int          burst_left = 0;
    int          live_chars = 0;    // characters seen outside an error
    int          bad_fields = 0;
    int unsigned cycle_cnt = 0;

    decimal_string_to_bcd_parser_top #(
        .COUNT_WIDTH (COUNT_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ch          (ch),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .digit       (digit),
        .sign        (sign),
        .digit_count (digit_count),
        .scale       (scale),
        .error       (error),
        .end_of_run  (end_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic flag_field(input string what, input longint got, input longint want);
        bad_fields++;
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    endtask

    task automatic clear_parse();
        num_phase  = dsbp_pkg::PH_SIGN;
        num_neg    = 1'b0;
        exp_neg    = 1'b0;
        exp_mag    = '0;
        frac_scale = '0;
        sig_digits = '0;
        parse_err  = dsbp_pkg::ERR_NONE;
    endtask

    // append one character to the string being built
    task automatic add_text(input logic [7:0] c);
        num_text.insert(num_text.size(), c);
    endtask

    // after a number body: space keeps waiting, E opens the exponent
    function automatic dsbp_pkg::phase_t after_marker(input logic [7:0] c);
        if (c == dsbp_pkg::CH_SPACE)
            return dsbp_pkg::PH_EMARK;
        if (c == dsbp_pkg::CH_EXP)
            return dsbp_pkg::PH_ESIGN;
        return dsbp_pkg::PH_ERR;
    endfunction

    // Advance the parse by one character and queue the beats it owes.
    // The phase checks run top to bottom so a character can drop through
    // several phases in one step, as the grammar allows.
    task automatic parse_char(input logic [7:0] c, input logic is_last);
        dsbp_pkg::phase_t  ph;
        logic              used;
        logic              got_digit;
        logic              is_dig;
        logic [3:0]        d;
        logic [31:0]       grown;
        int                sc;
        dsbp_pkg::result_t beat;
        is_dig    = (c >= dsbp_pkg::CH_ZERO) && (c <= dsbp_pkg::CH_NINE);
        d         = 4'(c - dsbp_pkg::CH_ZERO);
        ph        = num_phase;
        used      = 1'b0;
        got_digit = 1'b0;
        if (parse_err == dsbp_pkg::ERR_NONE)
        begin
            if (ph == dsbp_pkg::PH_SIGN)
            begin
                if (c == dsbp_pkg::CH_ZERO)
                    used = 1'b1;
                else
                begin
                    ph = dsbp_pkg::PH_LZERO;
                    if (c == dsbp_pkg::CH_MINUS || c == dsbp_pkg::CH_PLUS)
                    begin
                        num_neg = (c == dsbp_pkg::CH_MINUS);
                        used    = 1'b1;
                    end
                end
            end
            if (!used && ph == dsbp_pkg::PH_LZERO)
            begin
                if (c == dsbp_pkg::CH_ZERO)
                    used = 1'b1;
                else
                    ph = dsbp_pkg::PH_INT;
            end
            if (!used && ph == dsbp_pkg::PH_INT)
            begin
                used = 1'b1;
                if (is_dig)
                    got_digit = 1'b1;
                else if (c == dsbp_pkg::CH_DOT)
                    ph = (sig_digits != 0) ? dsbp_pkg::PH_FRAC : dsbp_pkg::PH_FZERO;
                else
                    ph = after_marker(c);
            end
            // zeros right after the point only move the scale
            if (!used && ph == dsbp_pkg::PH_FZERO)
            begin
                if (c == dsbp_pkg::CH_ZERO)
                begin
                    if (frac_scale != SCALE_TOP)
                        frac_scale++;
                    used = 1'b1;
                end
                else
                    ph = dsbp_pkg::PH_FRAC;
            end
            if (!used && ph == dsbp_pkg::PH_FRAC)
            begin
                used = 1'b1;
                if (is_dig)
                begin
                    got_digit = 1'b1;
                    if (frac_scale != SCALE_TOP)
                        frac_scale++;
                end
                else
                    ph = after_marker(c);
            end
            if (!used && ph == dsbp_pkg::PH_EMARK)
            begin
                used = 1'b1;
                ph   = after_marker(c);
            end
            if (!used && ph == dsbp_pkg::PH_ESIGN)
            begin
                ph = dsbp_pkg::PH_EZERO;
                if (c == dsbp_pkg::CH_MINUS || c == dsbp_pkg::CH_PLUS)
                begin
                    exp_neg = (c == dsbp_pkg::CH_MINUS);
                    used    = 1'b1;
                end
            end
            if (!used && ph == dsbp_pkg::PH_EZERO)
            begin
                if (c == dsbp_pkg::CH_ZERO)
                    used = 1'b1;
                else
                    ph = dsbp_pkg::PH_EDIG;
            end
            if (!used && ph == dsbp_pkg::PH_EDIG)
            begin
                if (!is_dig)
                    ph = dsbp_pkg::PH_ERR;
                else
                begin
                    grown = 32'(exp_mag) * 32'(dsbp_pkg::RADIX) + 32'(d);
                    if (grown > EXP_LIMIT)
                    begin
                        ph        = dsbp_pkg::PH_ERR;
                        parse_err = dsbp_pkg::ERR_EXPOVF;
                    end
                    else
                        exp_mag = grown[15:0];
                end
            end
            if (ph == dsbp_pkg::PH_ERR && parse_err == dsbp_pkg::ERR_NONE)
                parse_err = dsbp_pkg::ERR_SYNTAX;
            num_phase = ph;
        end

        if (got_digit)
        begin
            if (sig_digits != COUNT_TOP)
                sig_digits++;
            beat       = '0;
            beat.digit = d;
            parsed_beats.insert(parsed_beats.size(), beat);
        end

        if (is_last)
        begin
            sc = 0;
            if (parse_err == dsbp_pkg::ERR_NONE)
            begin
                sc = int'(frac_scale);
                if (exp_neg)
                    sc = sc + int'(exp_mag);
                else
                    sc = sc - int'(exp_mag);
                if (sc > 32767 || sc < -32768)
                    parse_err = dsbp_pkg::ERR_SCLOVF;
            end
            beat             = '0;
            beat.kind        = 1'b1;
            beat.end_of_run  = 1'b1;
            beat.error       = parse_err;
            beat.digit_count = (sig_digits > 16'hFFFF) ? 16'hFFFF : 16'(sig_digits);
            // error or no significant digit: sign and scale read as zero
            if (parse_err == dsbp_pkg::ERR_NONE && sig_digits != 0)
            begin
                beat.sign  = num_neg;
                beat.scale = 16'(sc);
            end
            parsed_beats.insert(parsed_beats.size(), beat);
            clear_parse();
        end
    endtask

    // Watch both sides. Inputs are stable from the falling edge, and the
    // block updates after this edge, so values read here are the ones it saw.
    always @(posedge clk)
    begin : watch
        dsbp_pkg::result_t want;
        dsbp_pkg::result_t typed_sum;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (parse_err == dsbp_pkg::ERR_NONE)
                    live_chars <= live_chars + 1;
                parse_char(ch, last);
                // typed table rows pin the summary directly
                if (last && row_tag >= 0 && dir_rows[row_tag].typed)
                begin
                    typed_sum = '{kind: 1'b1, digit: 4'd0, sign: dir_rows[row_tag].sign,
                                  digit_count: dir_rows[row_tag].count,
                                  scale: dir_rows[row_tag].scale,
                                  error: dir_rows[row_tag].err, end_of_run: 1'b1};
                    if (parsed_beats[parsed_beats.size() - 1] != typed_sum)
                        flag_field($sformatf("table row %0d summary", row_tag),
                                   longint'(parsed_beats[parsed_beats.size() - 1]),
                                   longint'(typed_sum));
                    parsed_beats[parsed_beats.size() - 1] = typed_sum;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (parsed_beats.size() == 0)
                    flag_field("beat with nothing owed, kind", longint'(kind), longint'(-1));
                else
                begin
                    want = parsed_beats.pop_front();
                    if (kind !== want.kind)
                        flag_field("kind", longint'(kind), longint'(want.kind));
                    if (digit !== want.digit)
                        flag_field("digit", longint'(digit), longint'(want.digit));
                    if (sign !== want.sign)
                        flag_field("sign", longint'(sign), longint'(want.sign));
                    if (digit_count !== want.digit_count)
                        flag_field("digit_count", longint'(digit_count),
                                   longint'(want.digit_count));
                    if (scale !== want.scale)
                        flag_field("scale", longint'(scale), longint'(want.scale));
                    if (error !== want.error)
                        flag_field("error", longint'(error), longint'(want.error));
                    if (end_of_run !== want.end_of_run)
                        flag_field("end_of_run", longint'(end_of_run),
                                   longint'(want.end_of_run));
                end
            end
        end
    end

    // Receiver: stall style changes every span of cycles.
    initial
    begin : receiver
        stall_style_t style;
        int           span;
        int           period;
        int           run_left;
        logic         held;
        run_left = 0;
        held     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            style  = stall_style_t'($urandom_range(0, 3));
            span   = $urandom_range(32, 256);
            period = $urandom_range(2, 5);
            for (int k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (style)
                    FLOW_FREE:     out_stall = 1'b0;
                    FLOW_SPARSE:   out_stall = ($urandom_range(0, 3) == 0);
                    FLOW_PERIODIC: out_stall = (k % period == 0);
                    default:
                    begin
                        // alternating runs of stall and no stall, each of random length
                        if (run_left == 0)
                        begin
                            run_left = $urandom_range(1, 8);
                            held     = !held;
                        end
                        out_stall = held;
                        run_left--;
                    end
                endcase
            end
        end
    end

    // One character beat. Bursts of random length with random idle gaps;
    // the bus carries junk while idle.
    task automatic send_char(input logic [7:0] c, input logic is_last, input int tag);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 14) : $urandom_range(0, 3);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                ch       = 8'($urandom);
                last     = 1'($urandom);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        ch       = c;
        last     = is_last;
        row_tag  = tag;
        do @(posedge clk); while (in_stall);
    endtask

    // stop sending until the block has returned everything it owes
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (parsed_beats.size() != 0)
            @(negedge clk);
    endtask

    // Random number string: mostly grammatical with random content, some
    // corrupted, some plain byte noise.
    task automatic compose_number();
        int    n;
        string mag_txt;
        num_text.delete();
        if ($urandom_range(0, 15) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) add_text(8'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) add_text(dsbp_pkg::CH_ZERO);
            case ($urandom_range(0, 2))
                0:       add_text(dsbp_pkg::CH_MINUS);
                1:       add_text(dsbp_pkg::CH_PLUS);
                default: ;
            endcase
            repeat ($urandom_range(0, 6))
                add_text(8'(dsbp_pkg::CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 1)
            begin
                add_text(dsbp_pkg::CH_DOT);
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) add_text(dsbp_pkg::CH_ZERO);
                repeat ($urandom_range(0, 5))
                    add_text(8'(dsbp_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2)) add_text(dsbp_pkg::CH_SPACE);
            if ($urandom_range(0, 4) < 2)
            begin
                add_text(dsbp_pkg::CH_EXP);
                case ($urandom_range(0, 2))
                    0:       add_text(dsbp_pkg::CH_MINUS);
                    1:       add_text(dsbp_pkg::CH_PLUS);
                    default: ;
                endcase
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) add_text(dsbp_pkg::CH_ZERO);
                // exponent: none, right at the overflow edge, wide, or small
                case ($urandom_range(0, 5))
                    0:       mag_txt = "";
                    1:       mag_txt = $sformatf("%0d", EXP_LIMIT + $urandom_range(0, 1));
                    2:       mag_txt = $sformatf("%0d", $urandom_range(0, 99999));
                    default: mag_txt = $sformatf("%0d", $urandom_range(0, 999));
                endcase
                for (int i = 0; i < mag_txt.len(); i++)
                    add_text(mag_txt[i]);
            end
            if (num_text.size() == 0)
                add_text(8'(dsbp_pkg::CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 7) == 0)
                num_text[$urandom_range(0, num_text.size() - 1)] = 8'($urandom);
            if ($urandom_range(0, 15) == 0)
                num_text.insert($urandom_range(0, num_text.size()), 8'($urandom));
        end
    endtask

    initial
    begin : stimulus
        int strings;
        strings = 0;
        clear_parse();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (dir_rows[r])
        begin
            for (int i = 0; i < dir_rows[r].text.len(); i++)
                send_char(dir_rows[r].text[i], i == dir_rows[r].text.len() - 1, r);
        end
        hold_until_drained();

        // random strings, with an occasional full drain
        while (live_chars < RANDOM_ITEMS)
        begin
            compose_number();
            foreach (num_text[i])
                send_char(num_text[i], i == num_text.size() - 1, -1);
            strings++;
            if (strings % 97 == 0)
                hold_until_drained();
        end
        hold_until_drained();

        // long negative integer
        send_char(dsbp_pkg::CH_MINUS, 1'b0, -1);
        for (int i = 0; i < LONG_RUN; i++)
            send_char(8'(dsbp_pkg::CH_ZERO + i % 10), i == LONG_RUN - 1, -1);

        hold_until_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (bad_fields == 0 && parsed_beats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
src/dsbp_pkg.sv
src/dsbp_front.sv
src/dsbp_back.sv
src/decimal_string_to_bcd_parser_top.sv
bench/testbench.sv
